>>> rtl/mdba_pkg.sv
// ----------------------------------------------------------------------------
// mdba_pkg
// shared constants, action codes and request/result types of the
// multichannel double-buffered accumulator core
// ----------------------------------------------------------------------------
package mdba_pkg;

  localparam int CHANNELS       = 4;
  localparam int SUM_BITS       = 16;
  localparam int NUM_COUNT_REGS = 4;

  localparam int COUNT_W    = 8;
  localparam int CHAN_W     = 2;
  localparam int SAMPLE_W   = 8;
  localparam int OUT_SUM_W  = 16;
  localparam int ACTION_W   = 2;
  localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_IDX_W  = 2;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // action codes; the spare code behaves as a read
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]           chan_out;
    logic                        block_done;
    logic signed [OUT_SUM_W-1:0] completed_sum;
  } out_rsp_t;

endpackage

>>> rtl/mdba_ram.sv
// ----------------------------------------------------------------------------
// mdba_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module mdba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/multichannel_double_buffered_accumulator_core.sv
// ----------------------------------------------------------------------------
// multichannel_double_buffered_accumulator_core
// four-channel integrate-and-dump accumulator with double-buffered sums
// ----------------------------------------------------------------------------
// One request per cycle is accepted and each gives exactly one result.
// An accepted request loads the read-stage registers as the sum rams
// register their read data; the read stage then adds and loads the output
// register, which drives out_valid, once that register is free. The
// rate is set by the single read-modify-write pass per request through the
// two sum rams (one per buffer, read at the request's channel); a write in
// flight to the entry being read is forwarded, so back-to-back requests to
// one channel need no bubble. While a result waits in the output register
// one more request is taken into the read stage, then the input stalls
// until the result is accepted. Per-channel buffer select, remaining-sample
// counter and a valid bit per sum entry live in flops: a reset request or a
// buffer swap clears entries by dropping valid bits, so no clearing pass is
// needed after reset. Count registers sit at byte addresses 0, 4, 8 and 12;
// a value of 0 means 256 samples and takes effect at the next reload.
// ----------------------------------------------------------------------------
module multichannel_double_buffered_accumulator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mdba_pkg::in_req_t                   in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output mdba_pkg::out_rsp_t                  out_data,
  // apb configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mdba_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mdba_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mdba_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CH  = mdba_pkg::CHANNELS;
  localparam int SB  = mdba_pkg::SUM_BITS;
  localparam int CIW = mdba_pkg::CHAN_IDX_W;
  localparam int CW  = mdba_pkg::COUNT_W;

  // configuration registers
  logic [CW-1:0] count_r [mdba_pkg::NUM_COUNT_REGS];
  logic          cfg_wr;

  // per-channel control state
  logic          active_r     [CH];
  logic          active_nxt   [CH];
  logic [CW-1:0] remaining_r  [CH];
  logic [CW-1:0] remaining_nxt[CH];
  logic [1:0]    vld_r        [CH];
  logic [1:0]    vld_nxt      [CH];

  // request stage
  logic           in_acc;
  logic           a_chan_ok;
  logic [CIW-1:0] a_idx;
  logic           a_is_add;
  logic           a_is_rst;
  logic           a_sel;
  logic [CW-1:0]  a_rem_dec;
  logic           a_done;
  logic           a_res_buf;
  logic [1:0]     a_vld;
  logic [1:0]     a_hit;

  // ram read stage
  logic                             b_valid_r;
  logic                             b_is_add_r;
  logic                             b_chan_ok_r;
  logic [mdba_pkg::CHAN_W-1:0]      b_chan_r;
  logic [CIW-1:0]                   b_idx_r;
  logic signed [mdba_pkg::SAMPLE_W-1:0] b_sample_r;
  logic                             b_act_r;
  logic                             b_done_r;
  logic                             b_res_buf_r;
  logic [1:0]                       b_vld_r;
  logic [1:0]                       b_hit_r;
  logic [SB-1:0]                    byp_data_r;
  logic                             b_adv;
  logic                             b_wr;

  logic [SB-1:0] q0, q1;
  logic [SB-1:0] eff0, eff1;
  logic [SB-1:0] act_val;
  logic [SB-1:0] res_val;
  logic [SB-1:0] sum_new;
  logic [mdba_pkg::OUT_SUM_W-1:0] b_result;

  // output register
  logic               out_valid_r;
  mdba_pkg::out_rsp_t out_data_r;

  // --------------------------------------------------------------------------
  // apb configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = mdba_pkg::APB_DATA_W'(count_r[paddr[3:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mdba_pkg::NUM_COUNT_REGS; i++) begin
        count_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      count_r[paddr[3:2]] <= pwdata[CW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // request stage: channel control decided from flops at accept
  // --------------------------------------------------------------------------
  assign b_adv    = b_valid_r && (!out_valid_r || out_ready);
  assign b_wr     = b_adv && b_is_add_r;
  assign in_ready = !b_valid_r || b_adv;
  assign in_acc   = in_valid && in_ready;

  assign a_chan_ok = int'(in_data.chan) < CH;
  assign a_idx     = CIW'(in_data.chan);
  assign a_is_add  = (in_data.action == mdba_pkg::ACT_ADD) && a_chan_ok;
  assign a_is_rst  = (in_data.action == mdba_pkg::ACT_RESET);
  assign a_sel     = active_r[a_idx];
  assign a_rem_dec = remaining_r[a_idx] - CW'(1);
  assign a_done    = a_is_add && (a_rem_dec == '0);

  // buffer the result comes from once this request is applied
  always_comb begin
    if (a_is_rst) begin
      a_res_buf = 1'b1;
    end else if (a_done) begin
      a_res_buf = a_sel;
    end else begin
      a_res_buf = ~a_sel;
    end
  end

  // entry validity and forwarding as seen after the older request's write
  always_comb begin
    a_vld = vld_r[a_idx];
    a_hit = 2'b00;
    if (b_wr && (b_idx_r == a_idx)) begin
      a_vld[b_act_r] = 1'b1;
      a_hit[b_act_r] = 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      active_nxt[c]    = active_r[c];
      remaining_nxt[c] = remaining_r[c];
      vld_nxt[c]       = vld_r[c];
    end
    // older request writes its active sum
    if (b_wr) begin
      vld_nxt[b_idx_r][b_act_r] = 1'b1;
    end
    // newer request's clears win over that write
    if (in_acc) begin
      if (a_is_rst) begin
        for (int c = 0; c < CH; c++) begin
          active_nxt[c]    = 1'b0;
          remaining_nxt[c] = count_r[mdba_pkg::CNT_IDX_W'(c % mdba_pkg::NUM_COUNT_REGS)];
          vld_nxt[c][0]    = 1'b0;
        end
      end else if (a_is_add) begin
        if (a_done) begin
          active_nxt[a_idx]        = ~a_sel;
          remaining_nxt[a_idx]     = count_r[mdba_pkg::CNT_IDX_W'(a_idx)];
          vld_nxt[a_idx][~a_sel]   = 1'b0;
        end else begin
          remaining_nxt[a_idx] = a_rem_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CH; c++) begin
        active_r[c]    <= 1'b0;
        remaining_r[c] <= '0;
        vld_r[c]       <= 2'b00;
      end
    end else begin
      for (int c = 0; c < CH; c++) begin
        active_r[c]    <= active_nxt[c];
        remaining_r[c] <= remaining_nxt[c];
        vld_r[c]       <= vld_nxt[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // sum rams, one per buffer, both read at the request's channel
  // --------------------------------------------------------------------------
  mdba_ram #(
    .WIDTH (SB),
    .DEPTH (CH)
  ) u_buf0_ram (
    .clk   (clk),
    .we    (b_wr && !b_act_r),
    .waddr (b_idx_r),
    .wdata (sum_new),
    .re    (in_acc),
    .raddr (a_idx),
    .rdata (q0)
  );

  mdba_ram #(
    .WIDTH (SB),
    .DEPTH (CH)
  ) u_buf1_ram (
    .clk   (clk),
    .we    (b_wr && b_act_r),
    .waddr (b_idx_r),
    .wdata (sum_new),
    .re    (in_acc),
    .raddr (a_idx),
    .rdata (q1)
  );

  // --------------------------------------------------------------------------
  // read stage: pick up ram data, add, write back
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_acc) begin
      b_valid_r <= 1'b1;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_is_add_r  <= a_is_add;
      b_chan_ok_r <= a_chan_ok;
      b_chan_r    <= in_data.chan;
      b_idx_r     <= a_idx;
      b_sample_r  <= in_data.sample;
      b_act_r     <= a_sel;
      b_done_r    <= a_done;
      b_res_buf_r <= a_res_buf;
      b_vld_r     <= a_vld;
      b_hit_r     <= a_hit;
      byp_data_r  <= sum_new;
    end
  end

  // entry value: forwarded write, else ram data if valid, else cleared
  assign eff0 = b_hit_r[0] ? byp_data_r : (b_vld_r[0] ? q0 : '0);
  assign eff1 = b_hit_r[1] ? byp_data_r : (b_vld_r[1] ? q1 : '0);

  assign act_val = b_act_r     ? eff1 : eff0;
  assign res_val = b_res_buf_r ? eff1 : eff0;
  assign sum_new = act_val + {{(SB-mdba_pkg::SAMPLE_W){b_sample_r[mdba_pkg::SAMPLE_W-1]}},
                              b_sample_r};

  always_comb begin
    if (!b_chan_ok_r) begin
      b_result = '0;
    end else if (b_done_r) begin
      b_result = sum_new[mdba_pkg::OUT_SUM_W-1:0];
    end else begin
      b_result = res_val[mdba_pkg::OUT_SUM_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data_r.chan_out      <= b_chan_r;
      out_data_r.block_done    <= b_done_r;
      out_data_r.completed_sum <= b_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a completed block only ever comes from an add
  a_done_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_done_r) |-> b_is_add_r)
    else $error("block_done on a request that is not an add");

  // forwarding targets at most one buffer
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> !(b_hit_r[0] && b_hit_r[1]))
    else $error("forwarding hit on both buffers");

  // after a swap the new active buffer reads as cleared
  a_swap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_done_r) |-> !vld_r[b_idx_r][~b_act_r])
    else $error("new active buffer not cleared after swap");

  // an empty read stage never blocks requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !b_valid_r |-> in_ready)
    else $error("request blocked while pipeline is empty");

  // a request accepted leaves the read stage occupied next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> b_valid_r)
    else $error("accepted request lost before read stage");

endmodule
